// ===== hdl/dictionary_key_compare_macros.svh =====
// Assertion macros used by the dictionary key compare RTL.
`ifndef DICTIONARY_KEY_COMPARE_MACROS_SVH
`define DICTIONARY_KEY_COMPARE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DKC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dictionary_key_compare: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dictionary_key_compare: next-cycle check failed");

`endif

// ===== hdl/dkc_pkg.sv =====
// Package with types, codes and character helpers for the key comparator.
`default_nettype none

package dkc_pkg;

    localparam int unsigned MAX_PATTERN = 255;

    localparam logic [1:0] CS_PLAIN = 2'd0;
    localparam logic [1:0] CS_LATIN = 2'd1;
    localparam logic [1:0] CS_JIS   = 2'd2;

    localparam logic [1:0] WE_ZERO = 2'd0;
    localparam logic [1:0] WE_SKIP = 2'd1;
    localparam logic [1:0] WE_NEG  = 2'd2;

    localparam logic REG_CHARSET = 1'b0;
    localparam logic REG_WORD_END = 1'b1;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CASE_BIT = 8'h20;
    localparam logic [7:0] JIS_ALNUM   = 8'h23;
    localparam logic [7:0] JIS_HIRA    = 8'h24;
    localparam logic [7:0] JIS_KATA    = 8'h25;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_CMP  = 4'b0010,
        PH_JIS2 = 4'b0100,
        PH_TAIL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] charset_mode;
        logic [1:0] word_end_rule;
    } cfg_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] word_byte;
        logic [7:0] pattern_byte;
        logic [7:0] pattern_length;
    } item_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] position;
        logic [7:0] length_held;
        logic [7:0] held_word_lead;
        logic [7:0] held_pattern_lead;
    } state_t;

    function automatic logic ascii_letter(input logic [7:0] c);
        ascii_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic latin_letter(input logic [7:0] c);
        latin_letter = ascii_letter(c)
            || (c >= 8'hC0 && c <= 8'hD6) || (c >= 8'hD8 && c <= 8'hDE)
            || (c >= 8'hE0 && c <= 8'hF6) || (c >= 8'hF8 && c <= 8'hFE);
    endfunction

    function automatic logic signed [8:0] byte_diff(input logic [7:0] a,
                                                     input logic [7:0] b);
        byte_diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dictionary_key_compare.sv =====
// Top level of the streaming dictionary key comparator.
// Usage:
// Each transfer on the s_ channel carries one word byte and the pattern byte at
// the same position. s_tuser marks the first position of a new comparison, and
// the pattern length for it rides in the top byte of s_tdata. A single signed
// order value leaves on the m_ channel once the comparison is decided: zero on
// a match, else its sign gives word against pattern. Items that decide nothing
// produce no transfer.
// The cfg channel writes charset mode (index 0) and word-end rule (index 1);
// it is always ready. The user must write it only while no item is in flight;
// the block itself does not enforce this. A transfer is captured in an input
// register and evaluated against the comparison state; its result is registered
// in the result register that drives m_tvalid. Throughput is one item per cycle
// while the receiver does not stall, set by the single evaluation stage between
// the input and result registers. Reset clears the comparison state to idle and
// both valid flags. When the receiver stalls, the result register holds and the
// input register absorbs one more item before s_tready falls.
`default_nettype none
`include "dictionary_key_compare_macros.svh"

module dictionary_key_compare
    import dkc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [7:0] word_byte, [15:8] pattern_byte, [23:16] pattern_length
    input  wire  [0:0]  s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [8:0] order, [15:9] zero
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [1:0]  cfg_data
);

    cfg_t              cfg;
    item_t             item_reg;
    logic              in_valid_reg;
    state_t            state_reg;
    state_t            state_next;
    logic              res_valid;
    logic signed [8:0] res_order;
    logic              out_valid_reg;
    logic signed [8:0] order_reg;
    logic              proc_fire;
    logic              s_fire;

    assign cfg_ready = 1'b1;

    dkc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The held item is evaluated when the result register is free to take its result.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.start_req      <= s_tuser[0];
            item_reg.word_byte      <= s_tdata[7:0];
            item_reg.pattern_byte   <= s_tdata[15:8];
            item_reg.pattern_length <= s_tdata[23:16];
        end
    end

    dkc_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res_order  (res_order)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, position: '0, length_held: '0,
                           held_word_lead: '0, held_pattern_lead: '0};
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res_valid)
            order_reg <= res_order;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, order_reg};

    `DKC_ASSERT_NEXT(a_result_ends_compare, proc_fire && res_valid, state_reg.phase == PH_IDLE)
    `DKC_ASSERT_NOW(a_open_pos_in_range,
        state_reg.phase == PH_TAIL || state_reg.phase == PH_JIS2,
        state_reg.position < state_reg.length_held)
    `DKC_ASSERT_NEXT(a_held_item_kept, in_valid_reg && !proc_fire, in_valid_reg)

endmodule

`default_nettype wire

// ===== hdl/dkc_cfg_regs.sv =====
// Configuration registers: charset mode and word-end rule.
`default_nettype none

module dkc_cfg_regs
    import dkc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_en,
    input  wire        wr_index,
    input  wire  [1:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{charset_mode: CS_PLAIN, word_end_rule: WE_ZERO};
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CHARSET:  cfg_reg.charset_mode  <= wr_data;
                REG_WORD_END: cfg_reg.word_end_rule <= wr_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/dkc_step.sv =====
// Per-item compare logic: next comparison state and the result, if decided.
`default_nettype none

module dkc_step
    import dkc_pkg::*;
(
    input  item_t             item,
    input  state_t            state,
    input  cfg_t              cfg,
    output state_t            state_next,
    output logic              res_valid,
    output logic signed [8:0] res_order
);

    state_t      st;
    logic [7:0]  w;
    logic [7:0]  p;
    logic [7:0]  pos_inc;
    logic [8:0]  pos_pair;
    logic        wl_kana;
    logic        pl_kana;

    assign w = item.word_byte;
    assign p = item.pattern_byte;

    always_comb
    begin
        st = state;
        if (item.start_req)
        begin
            if (32'(item.pattern_length) > MAX_PATTERN)
                st.length_held = 8'(MAX_PATTERN);
            else
                st.length_held = item.pattern_length;
            st.position = '0;
            st.phase    = PH_CMP;
        end
    end

    assign pos_inc  = st.position + 8'd1;
    assign pos_pair = {1'b0, st.position} + 9'd1;
    assign wl_kana  = (st.held_word_lead == JIS_HIRA) || (st.held_word_lead == JIS_KATA);
    assign pl_kana  = (st.held_pattern_lead == JIS_HIRA)
                   || (st.held_pattern_lead == JIS_KATA);

    always_comb
    begin
        state_next = st;
        res_valid  = 1'b0;
        res_order  = '0;
        case (st.phase)
            PH_IDLE:
            begin
                res_valid = 1'b0;
            end
            PH_TAIL:
            begin
                // Trailing spaces and zero bytes of the pattern are skipped.
                if (st.position >= st.length_held)
                    res_valid = 1'b1;
                else if (p == CH_SPACE || p == 8'd0)
                begin
                    state_next.position = pos_inc;
                    if (pos_inc >= st.length_held)
                        res_valid = 1'b1;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_order = byte_diff(st.position, st.length_held);
                end
            end
            PH_JIS2:
            begin
                if (w == 8'd0)
                begin
                    res_valid = 1'b1;
                    res_order = byte_diff(st.held_word_lead, st.held_pattern_lead);
                end
                else if (wl_kana && pl_kana)
                begin
                    if (w != p)
                    begin
                        res_valid = 1'b1;
                        res_order = byte_diff(w, p);
                    end
                end
                else if (st.held_word_lead == JIS_ALNUM && st.held_pattern_lead == JIS_ALNUM
                         && ascii_letter(w))
                begin
                    if ((w | CH_CASE_BIT) != (p | CH_CASE_BIT))
                    begin
                        res_valid = 1'b1;
                        res_order = byte_diff(w, p);
                    end
                end
                else if (st.held_word_lead != st.held_pattern_lead)
                begin
                    res_valid = 1'b1;
                    res_order = byte_diff(st.held_word_lead, st.held_pattern_lead);
                end
                else if (w != p)
                begin
                    res_valid = 1'b1;
                    res_order = byte_diff(w, p);
                end
                if (!res_valid)
                begin
                    state_next.position = pos_inc;
                    state_next.phase    = PH_CMP;
                end
            end
            PH_CMP:
            begin
                if (st.position >= st.length_held)
                begin
                    res_valid = 1'b1;
                    res_order = $signed({1'b0, w});
                end
                else if (w == 8'd0)
                begin
                    if (cfg.word_end_rule == WE_SKIP)
                    begin
                        // Same handling as a tail item, starting at this position.
                        state_next.phase = PH_TAIL;
                        if (p == CH_SPACE || p == 8'd0)
                        begin
                            state_next.position = pos_inc;
                            if (pos_inc >= st.length_held)
                                res_valid = 1'b1;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res_order = byte_diff(st.position, st.length_held);
                        end
                    end
                    else if (cfg.word_end_rule == WE_NEG)
                    begin
                        res_valid = 1'b1;
                        res_order = 9'sd0 - $signed({1'b0, p});
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
                else if (cfg.charset_mode == CS_JIS)
                begin
                    if (pos_pair >= {1'b0, st.length_held})
                    begin
                        res_valid = 1'b1;
                        res_order = byte_diff(w, p);
                    end
                    else
                    begin
                        state_next.held_word_lead    = w;
                        state_next.held_pattern_lead = p;
                        state_next.position          = pos_inc;
                        state_next.phase             = PH_JIS2;
                    end
                end
                else if (cfg.charset_mode == CS_LATIN && latin_letter(w))
                begin
                    if ((w | CH_CASE_BIT) != (p | CH_CASE_BIT))
                    begin
                        res_valid = 1'b1;
                        res_order = byte_diff(w, p);
                    end
                    else
                        state_next.position = pos_inc;
                end
                else if (w != p)
                begin
                    res_valid = 1'b1;
                    res_order = byte_diff(w, p);
                end
                else
                    state_next.position = pos_inc;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
        if (res_valid)
            state_next.phase = PH_IDLE;
    end

endmodule

`default_nettype wire
